FILE: hw/rtl/iira_pkg.sv
package iira_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned STAT_W = 2;

  // Default sizing of the array
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_READ   = 2'd0,
    FN_WRITE  = 2'd1,
    FN_INSERT = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             wr;   // overwrite the cell at idx
    logic             ins;  // the cell at idx takes the new word, cells above idx take the lower neighbour
    logic             rem;  // cells at or above idx take the upper neighbour
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/iira_in_if.sv
interface iira_in_if;
  logic                           valid;
  logic                           ready;
  logic [iira_pkg::FUNC_W-1:0]    func;
  logic [iira_pkg::IDX_W-1:0]     index;
  logic [iira_pkg::VAL_W-1:0]     value;

  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

FILE: hw/rtl/iira_out_if.sv
interface iira_out_if;
  logic                           valid;
  logic                           ready;
  logic [iira_pkg::VAL_W-1:0]     read_value;
  logic [iira_pkg::CNT_W-1:0]     count;
  logic [iira_pkg::STAT_W-1:0]    status;

  modport source (output valid, read_value, count, status, input ready);
  modport sink   (input valid, read_value, count, status, output ready);
endinterface

FILE: hw/rtl/iira_cell.sv
module iira_cell #(
  parameter int unsigned POS        = 0,
  parameter int unsigned DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  iira_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]  wr_data,
  input  logic [DATA_WIDTH-1:0]  lower_data,
  input  logic [DATA_WIDTH-1:0]  upper_data,
  output logic [DATA_WIDTH-1:0]  data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  at_idx;
  logic                  above_idx;

  assign at_idx    = (POS == int'(ctrl.idx));
  assign above_idx = (POS >  int'(ctrl.idx));

  // Select: hold, new word, or shift from a neighbour
  always_comb begin
    data_nxt = data_r;
    priority if ((ctrl.wr || ctrl.ins) && at_idx) begin
      data_nxt = wr_data;
    end else if (ctrl.ins && above_idx) begin
      data_nxt = lower_data;
    end else if (ctrl.rem && (at_idx || above_idx)) begin
      data_nxt = upper_data;
    end else begin
      data_nxt = data_r;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: hw/rtl/indexed_insert_remove_array_top.sv
// Ordered array of up to DEPTH words held in a row of cells, one word per
// cell. On a read, write, insert or remove every cell loads its new word,
// its own or a neighbour's, at the same clock edge, so an insert or remove
// shifts the whole tail at once. One transaction is accepted per cycle and
// its result appears in the output register on the next cycle; the input
// stalls only in reset or while that result is held by the sink. Each result
// carries the read word (zero unless a read succeeded), the element count
// after the operation and a status. Entries are only readable below the
// count; there is no clearing pass after reset.
module indexed_insert_remove_array_top #(
  parameter int unsigned DEPTH      = iira_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  iira_in_if.sink    in_if,
  iira_out_if.source out_if
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > iira_pkg::IDX_W) ? CW : iira_pkg::IDX_W;
  localparam int unsigned N_RD  = (DEPTH < (1 << iira_pkg::IDX_W)) ?
                                  DEPTH : (1 << iira_pkg::IDX_W);

  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic                   out_valid_r;
  logic [iira_pkg::VAL_W-1:0]  rd_val_r;
  logic [iira_pkg::CNT_W-1:0]  out_cnt_r;
  iira_pkg::status_t      status_r;

  logic                   accept;
  iira_pkg::func_t        func;
  logic [CMP_W-1:0]       idx_w;
  logic [CMP_W-1:0]       cnt_w;
  logic                   full;
  logic                   in_rng;
  logic                   ins_rng;
  iira_pkg::status_t      status;
  iira_pkg::cell_ctrl_t   ctrl;
  logic [63:0]            val_ext;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic [DATA_WIDTH-1:0]  ent [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_data;
  logic [63:0]            rd_ext;

  // Handshake: output register frees the input side; nothing taken in reset
  assign in_if.ready = rst_n && (!out_valid_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  // Range checks on the request
  assign func    = iira_pkg::func_t'(in_if.func);
  assign idx_w   = CMP_W'(in_if.index);
  assign cnt_w   = CMP_W'(cnt_r);
  assign full    = (cnt_r == CW'(DEPTH));
  assign in_rng  = (idx_w <  cnt_w);
  assign ins_rng = (idx_w <= cnt_w);

  // Status, count update and cell control
  always_comb begin
    status   = iira_pkg::ST_OK;
    cnt_nxt  = cnt_r;
    ctrl.wr  = 1'b0;
    ctrl.ins = 1'b0;
    ctrl.rem = 1'b0;
    ctrl.idx = in_if.index;
    unique case (func)
      iira_pkg::FN_READ: begin
        if (!in_rng) status = iira_pkg::ST_RANGE;
      end
      iira_pkg::FN_WRITE: begin
        if (!in_rng) status = iira_pkg::ST_RANGE;
        else         ctrl.wr = accept;
      end
      iira_pkg::FN_INSERT: begin
        if (full) begin
          status = iira_pkg::ST_FULL;
        end else if (!ins_rng) begin
          status = iira_pkg::ST_RANGE;
        end else begin
          ctrl.ins = accept;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      iira_pkg::FN_REMOVE: begin
        if (!in_rng) begin
          status = iira_pkg::ST_RANGE;
        end else begin
          ctrl.rem = accept;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: status = iira_pkg::ST_OK;
    endcase
  end

  // Keep the low DATA_WIDTH bits of the incoming word
  assign val_ext = 64'(in_if.value);
  assign wr_data = val_ext[DATA_WIDTH-1:0];

  // Row of cells, each wired to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower;
    logic [DATA_WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lo
      assign lower = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = ent[i];
    end else begin : g_hi
      assign upper = ent[i+1];
    end
    iira_cell #(
      .POS        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wr_data    (wr_data),
      .lower_data (lower),
      .upper_data (upper),
      .data       (ent[i])
    );
  end

  // Read select over the cells the index can reach
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < N_RD; k++) begin
      if (int'(in_if.index) == k) rd_data = ent[k];
    end
  end
  assign rd_ext = 64'(rd_data);

  // Count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      rd_val_r  <= ((func == iira_pkg::FN_READ) && (status == iira_pkg::ST_OK)) ?
                   rd_ext[iira_pkg::VAL_W-1:0] : '0;
      out_cnt_r <= iira_pkg::CNT_W'(cnt_nxt);
      status_r  <= status;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = rd_val_r;
  assign out_if.count      = out_cnt_r;
  assign out_if.status     = status_r;

endmodule

FILE: hw/rtl/iira_checker.sv
module iira_checker #(
  parameter int unsigned DEPTH = iira_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [iira_pkg::VAL_W-1:0]    out_read_value,
  input logic [iira_pkg::CNT_W-1:0]    out_count,
  input logic [iira_pkg::STAT_W-1:0]   out_status
);

  // Every accepted transaction shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) &&
      $stable(out_count) && $stable(out_status))
    else $error("stalled result changed");

  // Failed operations return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != iira_pkg::ST_OK) |-> out_read_value == '0)
    else $error("failed operation returned data");

  // Full error only when the array is full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == iira_pkg::ST_FULL) |->
      out_count == iira_pkg::CNT_W'(DEPTH))
    else $error("full status with array not full");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH >= 32) || (int'(out_count) <= DEPTH))
    else $error("count exceeds capacity");

endmodule

bind indexed_insert_remove_array_top iira_checker #(.DEPTH(DEPTH)) u_iira_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_read_value (out_if.read_value),
  .out_count      (out_if.count),
  .out_status     (out_if.status)
);

FILE: tb/indexed_insert_remove_array_top_tb.sv
`timescale 1ns / 100ps

module indexed_insert_remove_array_top_tb;

  localparam int unsigned ARRAY_DEPTH = iira_pkg::DEPTH_DEF;
  localparam int unsigned WORD_W      = iira_pkg::DATA_WIDTH_DEF;
  localparam int unsigned IW          = iira_pkg::IDX_W;
  localparam int unsigned VW          = iira_pkg::VAL_W;
  localparam int unsigned NW          = iira_pkg::CNT_W;
  localparam int unsigned STALL_LIMIT = 2000;   // cycles with no transaction at all
  localparam int unsigned HOLD_CYCLES = 400;    // long sink hold-off

  typedef struct {
    logic [VW-1:0]     read_value;
    logic [NW-1:0]     count;
    iira_pkg::status_t status;
  } array_result_t;

  logic clk;
  logic rst_n;

  iira_in_if  in_ch ();
  iira_out_if out_ch ();

  indexed_insert_remove_array_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Shadow copy of the array contents and fill level
  logic [WORD_W-1:0] shadow_words [ARRAY_DEPTH];
  int unsigned       shadow_count = 0;
  array_result_t     pending_results [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_req        = 0;
  int unsigned quiet_cycles    = 0;
  bit          failed          = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one operation to the shadow array and return the result it gives
  function automatic array_result_t apply_op(iira_pkg::func_t f, logic [IW-1:0] idx,
                                             logic [VW-1:0] val);
    array_result_t res;
    int unsigned   i;
    res.read_value = '0;
    res.status     = iira_pkg::ST_OK;
    case (f)
      iira_pkg::FN_READ: begin
        if (idx < shadow_count) res.read_value = VW'(shadow_words[idx]);
        else res.status = iira_pkg::ST_RANGE;
      end
      iira_pkg::FN_WRITE: begin
        if (idx < shadow_count) shadow_words[idx] = val[WORD_W-1:0];
        else res.status = iira_pkg::ST_RANGE;
      end
      iira_pkg::FN_INSERT: begin
        // full takes precedence over a bad index
        if (shadow_count >= ARRAY_DEPTH) begin
          res.status = iira_pkg::ST_FULL;
        end else if (idx > shadow_count) begin
          res.status = iira_pkg::ST_RANGE;
        end else begin
          for (i = shadow_count; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = val[WORD_W-1:0];
          shadow_count++;
        end
      end
      iira_pkg::FN_REMOVE: begin
        if (idx < shadow_count) begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end else begin
          res.status = iira_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[NW-1:0];
    return res;
  endfunction

  // Predict on each input transaction, then check any result transaction
  always @(posedge clk) begin : result_monitor
    array_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_results = {pending_results,
                           apply_op(iira_pkg::func_t'(in_ch.func), in_ch.index,
                                    in_ch.value)};
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: read_value %h count %0d status %0d",
                 out_ch.read_value, out_ch.count, out_ch.status);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_ch.read_value);
            failed = 1'b1;
          end
          if (out_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_ch.count);
            failed = 1'b1;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("indexed_insert_remove_array_top_tb NOT OK");
      $finish;
    end
  end

  // Result sink: random stalls, or a long hold-off on request
  initial begin : sink_ready
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Offer one transaction, with random idle cycles first; returns at acceptance
  task automatic send_op(iira_pkg::func_t f, logic [IW-1:0] idx, logic [VW-1:0] val);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.index <= idx;
    in_ch.value <= val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Edges of the index range, append, shifts, full and last-entry removal
  task automatic test_directed();
    int unsigned k;
    logic [IW-1:0] idx;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // empty array: everything out of range except insert at 0
    send_op(iira_pkg::FN_READ,   4'd0,  32'h0);
    send_op(iira_pkg::FN_WRITE,  4'd15, 32'hFFFF_FFFF);
    send_op(iira_pkg::FN_REMOVE, 4'd0,  32'h0);
    send_op(iira_pkg::FN_INSERT, 4'd1,  32'h1234_5678);
    send_op(iira_pkg::FN_INSERT, 4'd0,  32'hFFFF_FFFF);
    send_op(iira_pkg::FN_INSERT, 4'd1,  32'h0000_0000);
    send_op(iira_pkg::FN_INSERT, 4'd0,  32'h8000_0001);
    // fill up with a mix of appends, front and middle inserts
    for (k = 3; k < ARRAY_DEPTH; k++) begin
      idx = (k % 3 == 0) ? IW'(k) : ((k % 3 == 1) ? '0 : IW'(k / 2));
      send_op(iira_pkg::FN_INSERT, idx,
              (k % 2) ? 32'h5555_5555 ^ k : 32'hAAAA_AAAA ^ k);
    end
    send_op(iira_pkg::FN_INSERT, 4'd15, 32'hDEAD_BEEF);
    send_op(iira_pkg::FN_INSERT, 4'd0,  32'hDEAD_BEEF);
    send_op(iira_pkg::FN_READ,   4'd15, 32'h0);
    send_op(iira_pkg::FN_WRITE,  4'd15, 32'h0);
    send_op(iira_pkg::FN_REMOVE, 4'd15, 32'h0);
    send_op(iira_pkg::FN_REMOVE, 4'd0,  32'h0);
    send_op(iira_pkg::FN_READ,   4'd0,  32'hFFFF_FFFF);
    send_op(iira_pkg::FN_WRITE,  4'd0,  32'hFFFF_FFFF);
  endtask

  // Random operations, drifting between filling and draining
  task automatic test_random(int unsigned n_items, int unsigned idle_pct,
                             int unsigned stall_pct);
    int unsigned      k;
    int unsigned      pick;
    int unsigned      hi;
    bit               grow;
    iira_pkg::func_t  f;
    logic [IW-1:0]    idx;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    grow = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 48 == 0) grow = 1'($urandom_range(1, 0));
      pick = $urandom_range(99, 0);
      if (pick < 20)                       f = iira_pkg::FN_READ;
      else if (pick < 40)                  f = iira_pkg::FN_WRITE;
      else if (pick < (grow ? 85 : 55))    f = iira_pkg::FN_INSERT;
      else                                 f = iira_pkg::FN_REMOVE;
      // mostly legal indexes; a tenth anywhere
      if (f == iira_pkg::FN_INSERT) hi = shadow_count;
      else hi = (shadow_count == 0) ? 0 : shadow_count - 1;
      if (hi > 15) hi = 15;
      if ($urandom_range(9, 0) == 0) idx = IW'($urandom_range(15, 0));
      else idx = IW'($urandom_range(hi, 0));
      send_op(f, idx, $urandom());
    end
  endtask

  // Sink holds off for a long stretch while the source keeps offering
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    test_random(40, 0, 0);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= iira_pkg::FN_READ;
    in_ch.index <= '0;
    in_ch.value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(500, 0, 0);
    test_random(500, 52, 0);
    test_backpressure();
    test_random(500, 0, 52);
    test_random(500, 19, 19);

    in_ch.valid <= 1'b0;
    // let the monitor record the last transaction before draining
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (!failed) begin
      $display("indexed_insert_remove_array_top_tb OK");
    end else begin
      $display("indexed_insert_remove_array_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: indexed_insert_remove_array_top.f
hw/rtl/iira_pkg.sv
hw/rtl/iira_in_if.sv
hw/rtl/iira_out_if.sv
hw/rtl/iira_cell.sv
hw/rtl/indexed_insert_remove_array_top.sv
hw/rtl/iira_checker.sv
tb/indexed_insert_remove_array_top_tb.sv
